@@ hw/rtl/cbm_pkg.sv @@
// shared types and constants of the console bank mapper
`default_nettype none

package cbm_pkg;

    localparam int DEF_MAX_ROM_PAGES = 256;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int PAGES_W = 9;
    localparam int BANK_W  = 9;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = KIND_W + BANK_W;
    localparam int OFF_W   = 13;
    localparam int TADDR_W = BANK_W + OFF_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_ROM     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAM     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SRAM    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_PAGES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CM_MODE   = 1'b1;

    localparam logic [ADDR_W-1:0] FRAME_BASE = 16'hFFFC;
    localparam logic [ADDR_W-1:0] CM_REG     = 16'h8000;

    localparam logic [1:0] FC_SLOT_CTRL = 2'd0;
    localparam logic [1:0] FC_BANK0     = 2'd1;
    localparam logic [1:0] FC_BANK1     = 2'd2;
    localparam logic [1:0] FC_BANK2     = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic apply;
        logic push;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_upd;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/cbm_if.sv @@
// channel interfaces of the console bank mapper
`default_nettype none

interface cbm_in_if;
    import cbm_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    modport source (output valid, output req_type, output address, output data, input ready);
    modport sink   (input valid, input req_type, input address, input data, output ready);
endinterface

interface cbm_out_if;
    import cbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  target;
    logic [TADDR_W-1:0] target_address;
    logic               store_write;
    logic               save_ram_used;
    modport source (output valid, output target, output target_address,
                    output store_write, output save_ram_used, input ready);
    modport sink   (input valid, input target, input target_address,
                    input store_write, input save_ram_used, output ready);
endinterface

interface cbm_cfg_if;
    import cbm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PAGES_W-1:0]   wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cbm_ctrl.sv @@
// sequencer of the console bank mapper
`default_nettype none

module cbm_ctrl
    import cbm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_sts  i_sts,
    output t_ctl_cmd      o_cmd,
    output logic          o_in_ready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    localparam int DIV_CYCLES = DATA_W / 2;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_sts.need_upd ? ST_DIV : ST_PUSH;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_PUSH;
            end
            ST_PUSH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cbm_datapath.sv @@
// slot tables, page remainder unit and result register of the bank mapper
`default_nettype none

module cbm_datapath
    import cbm_pkg::*;
#(
    parameter int MAX_ROM_PAGES = DEF_MAX_ROM_PAGES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl_cmd             i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic                 i_req_type,
    input  wire logic [ADDR_W-1:0]    i_address,
    input  wire logic [DATA_W-1:0]    i_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [PAGES_W-1:0]   i_cfg_wdata,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [KIND_W-1:0]         o_target,
    output logic [TADDR_W-1:0]        o_target_address,
    output logic                      o_store_write,
    output logic                      o_save_ram_used
);

    function automatic logic [PAGES_W-1:0] f_rem_step(
        input logic [PAGES_W-1:0] r,
        input logic               b,
        input logic [PAGES_W-1:0] d
    );
        logic [PAGES_W-1:0] t;
        t = {r[PAGES_W-2:0], b};
        return (t >= d) ? t - d : t;
    endfunction

    // config
    logic [PAGES_W-1:0] r_rom_pages;
    logic               r_cm_mode;

    // mapping state
    logic [SLOT_W-1:0] r_rd_slot [8];
    logic [SLOT_W-1:0] r_wr_slot [8];
    logic [DATA_W-1:0] r_fc [4];
    logic              r_save;

    // item in flight
    logic [ADDR_W-1:0]  r_addr;
    logic [DATA_W-1:0]  r_data;
    logic               r_cm_hit;
    logic [DATA_W-1:0]  r_dvd;
    logic [PAGES_W-1:0] r_rem;
    logic [KIND_W-1:0]  r_res_kind;
    logic [TADDR_W-1:0] r_res_taddr;
    logic               r_res_sw;

    // result register
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [TADDR_W-1:0] r_out_taddr;
    logic               r_out_sw;
    logic               r_out_save;

    logic [PAGES_W-1:0] w_div;
    logic [2:0]         w_slot;
    logic [OFF_W-1:0]   w_off;
    logic               w_cm_hit;
    logic               w_frame_hit;
    logic [SLOT_W-1:0]  w_rd_s;
    logic [SLOT_W-1:0]  w_wr_s;
    logic [KIND_W-1:0]  w_kind;
    logic [TADDR_W-1:0] w_taddr;
    logic               w_sw;
    logic [DATA_W-1:0]  w_op;
    logic [PAGES_W-1:0] w_rem_a;
    logic [PAGES_W-1:0] w_rem_b;
    logic [BANK_W-1:0]  w_bank0;
    logic [BANK_W-1:0]  w_bank1;
    logic [BANK_W-1:0]  w_sbank0;
    logic [BANK_W-1:0]  w_sbank1;
    logic [1:0]         w_reg;

    always_comb begin
        if (r_rom_pages == '0) begin
            w_div = PAGES_W'(1);
        end else if (r_rom_pages > PAGES_W'(MAX_ROM_PAGES)) begin
            w_div = PAGES_W'(MAX_ROM_PAGES);
        end else begin
            w_div = r_rom_pages;
        end
    end

    assign w_slot      = i_address[ADDR_W-1 -: 3];
    assign w_off       = i_address[OFF_W-1:0];
    assign w_cm_hit    = i_req_type && r_cm_mode && (i_address == CM_REG);
    assign w_frame_hit = i_req_type && !r_cm_mode && (i_address >= FRAME_BASE);
    assign w_rd_s      = r_rd_slot[w_slot];
    assign w_wr_s      = r_wr_slot[w_slot];
    // frame control write on slot control register rebanks with the last bank 2 value
    assign w_op        = (w_frame_hit && i_address[1:0] == FC_SLOT_CTRL) ? r_fc[FC_BANK2]
                                                                          : i_data;

    always_comb begin
        w_kind  = KIND_DISCARD;
        w_taddr = '0;
        w_sw    = 1'b0;
        if (!i_req_type) begin
            w_kind  = w_rd_s[SLOT_W-1 -: KIND_W];
            w_taddr = {w_rd_s[BANK_W-1:0], w_off};
        end else if (!w_cm_hit) begin
            w_kind = w_wr_s[SLOT_W-1 -: KIND_W];
            if (w_wr_s[SLOT_W-1 -: KIND_W] != KIND_DISCARD) begin
                w_taddr = {w_wr_s[BANK_W-1:0], w_off};
                w_sw    = 1'b1;
            end
        end
    end

    assign o_sts.need_upd = w_cm_hit || w_frame_hit;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // two remainder steps per cycle
    assign w_rem_a = f_rem_step(r_rem, r_dvd[DATA_W-1], w_div);
    assign w_rem_b = f_rem_step(w_rem_a, r_dvd[DATA_W-2], w_div);

    assign w_bank0  = {r_rem[DATA_W-1:0], 1'b0};
    assign w_bank1  = {r_rem[DATA_W-1:0], 1'b1};
    assign w_sbank0 = {{(BANK_W-2){1'b0}}, r_data[2], 1'b0};
    assign w_sbank1 = {{(BANK_W-2){1'b0}}, r_data[2], 1'b1};
    assign w_reg    = r_addr[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_pages <= PAGES_W'(1);
            r_cm_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROM_PAGES: r_rom_pages <= i_cfg_wdata;
                CFG_CM_MODE:   r_cm_mode   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_rd_slot[i] <= {KIND_ROM, BANK_W'(i)};
                r_wr_slot[i] <= {KIND_DISCARD, BANK_W'(0)};
            end
            for (int i = 6; i < 8; i++) begin
                r_rd_slot[i] <= {KIND_RAM, BANK_W'(0)};
                r_wr_slot[i] <= {KIND_RAM, BANK_W'(0)};
            end
            r_fc[0] <= 8'd0;
            r_fc[1] <= 8'd0;
            r_fc[2] <= 8'd1;
            r_fc[3] <= 8'd0;
            r_save  <= 1'b0;
        end else if (i_cmd.apply) begin
            if (r_cm_hit) begin
                r_rd_slot[4] <= {KIND_ROM, w_bank0};
                r_rd_slot[5] <= {KIND_ROM, w_bank1};
            end else begin
                r_fc[w_reg] <= r_data;
                case (w_reg)
                    FC_SLOT_CTRL: begin
                        if (r_data[3]) begin
                            r_save       <= 1'b1;
                            r_rd_slot[4] <= {KIND_SRAM, w_sbank0};
                            r_rd_slot[5] <= {KIND_SRAM, w_sbank1};
                            r_wr_slot[4] <= {KIND_SRAM, w_sbank0};
                            r_wr_slot[5] <= {KIND_SRAM, w_sbank1};
                        end else begin
                            r_rd_slot[4] <= {KIND_ROM, w_bank0};
                            r_rd_slot[5] <= {KIND_ROM, w_bank1};
                            r_wr_slot[4] <= {KIND_DISCARD, BANK_W'(0)};
                            r_wr_slot[5] <= {KIND_DISCARD, BANK_W'(0)};
                        end
                    end
                    FC_BANK0: begin
                        r_rd_slot[0] <= {KIND_ROM, w_bank0};
                        r_rd_slot[1] <= {KIND_ROM, w_bank1};
                    end
                    FC_BANK1: begin
                        r_rd_slot[2] <= {KIND_ROM, w_bank0};
                        r_rd_slot[3] <= {KIND_ROM, w_bank1};
                    end
                    default: begin
                        if (!r_fc[FC_SLOT_CTRL][3]) begin
                            r_rd_slot[4] <= {KIND_ROM, w_bank0};
                            r_rd_slot[5] <= {KIND_ROM, w_bank1};
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr      <= i_address;
            r_data      <= i_data;
            r_cm_hit    <= w_cm_hit;
            r_dvd       <= w_op;
            r_rem       <= '0;
            r_res_kind  <= w_kind;
            r_res_taddr <= w_taddr;
            r_res_sw    <= w_sw;
        end else if (i_cmd.step) begin
            r_dvd <= {r_dvd[DATA_W-3:0], 2'b00};
            r_rem <= w_rem_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_kind  <= r_res_kind;
            r_out_taddr <= r_res_taddr;
            r_out_sw    <= r_res_sw;
            r_out_save  <= r_save;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_target         = r_out_kind;
    assign o_target_address = r_out_taddr;
    assign o_store_write    = r_out_sw;
    assign o_save_ram_used  = r_out_save;

endmodule

`default_nettype wire

@@ hw/rtl/console_bank_mapper.sv @@
// a read or plain write goes from its load in the idle state to the push state, then to the result register
// a mapper register write passes the divide, apply and push states before the result register; push waits on a stall
// a new input is taken only in the idle state, after the previous item has been pushed
// the page remainder unit works through 2 quotient bits per cycle
// reset: synchronous active low, restores power-up slot map and config
`default_nettype none

module console_bank_mapper
    import cbm_pkg::*;
#(
    parameter int MAX_ROM_PAGES = DEF_MAX_ROM_PAGES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbm_in_if.sink     i_in,
    cbm_out_if.source  o_out,
    cbm_cfg_if.sink    i_cfg
);

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;
    logic     w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    cbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    cbm_datapath #(
        .MAX_ROM_PAGES (MAX_ROM_PAGES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_type       (i_in.req_type),
        .i_address        (i_in.address),
        .i_data           (i_in.data),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_wdata      (i_cfg.wdata),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_target         (o_out.target),
        .o_target_address (o_out.target_address),
        .o_store_write    (o_out.store_write),
        .o_save_ram_used  (o_out.save_ram_used)
    );

endmodule

`default_nettype wire

@@ hw/rtl/cbm_checker.sv @@
// port checker of the console bank mapper and its bind
`default_nettype none

module cbm_checker
    import cbm_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [KIND_W-1:0]  i_target,
    input wire logic [TADDR_W-1:0] i_target_address,
    input wire logic               i_store_write
);

    // one item at a time
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_target)
            && $stable(i_target_address) && $stable(i_store_write))
        else $error("stalled result changed");

    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_target == KIND_DISCARD |-> i_target_address == '0 && !i_store_write)
        else $error("discarded write carries offset or store write");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind console_bank_mapper cbm_checker u_cbm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_target         (o_out.target),
    .i_target_address (o_out.target_address),
    .i_store_write    (o_out.store_write)
);

`default_nettype wire
